// ===== rtl/core/slp_pkg.sv =====
// Shared constants, status codes and size check for the stripe layout planner.
`default_nettype none

package slp_pkg;

  localparam int unsigned DEFAULT_MAX_DEVICES = 8;
  localparam int unsigned UNIT_W   = 31;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BLOCK_W  = 35;
  localparam int unsigned WIDTH_W  = 4;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic [WORD_W-1:0] HEADER_SECTORS = 32'd32;
  localparam logic [UNIT_W-1:0] DEFAULT_UNIT   = 31'd2048;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ROW       = 2'd0;
  localparam status_t ST_TOO_SMALL = 2'd1;
  localparam status_t ST_TOO_FEW   = 2'd2;
  localparam status_t ST_TOO_MANY  = 2'd3;

  function automatic logic too_small(input logic [WORD_W-1:0] size,
                                     input logic [UNIT_W-1:0] unit);
    logic [WORD_W:0] limit;
    begin
      limit = {2'b00, unit} + {1'b0, HEADER_SECTORS};
      if (unit != '0) begin
        too_small = {1'b0, size} < limit;
      end else begin
        too_small = size <= HEADER_SECTORS;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stripe_layout_planner_top.sv =====
// Top level of the stripe layout planner: member memories and plan sequencer.
// Usage:
//   Input channel (in_valid / in_stall): one beat per member disk carrying
//   device_id, device_size and last_device. A beat is taken
//   while the sequencer is idle; a beat with last_device set closes the set
//   and starts planning, during which in_stall stays high.
//   Output channel (out_valid / out_stall): one beat per row member, or one
//   error beat. last_member marks the end of a row, last_result the end of
//   the plan.
//   cfg_we / cfg_data write stripe_unit (zero means concatenation).
//   Sequence: planning walks the member memories with a read step and a
//   use step per entry: a check pass over all N disks, then per row a
//   minimum pass over L members, a restoring divide, step math in S_STEP
//   and S_NEXT, an emit pass over L and a compaction pass over L, where
//   L is the row's width. Concatenation emits one member per disk.
//   Reset: stripe_unit returns to 2048 and the set is empty; the memories
//   keep their contents and are only read below the disk count.
//   Stall: the emitting states hold in place while the output register is full
//   and stalled; a new input beat is taken as soon as the last result of a
//   plan sits in the output register.
`default_nettype none

module stripe_layout_planner_top
  import slp_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = DEFAULT_MAX_DEVICES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [UNIT_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [WORD_W-1:0]    device_id,
  input  wire logic [WORD_W-1:0]    device_size,
  input  wire logic                 last_device,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output status_t                   status,
  output logic [BLOCK_W-1:0]        first_block,
  output logic [BLOCK_W-1:0]        last_block,
  output logic [WORD_W-1:0]         start_offset,
  output logic [WIDTH_W-1:0]        row_width,
  output logic [WORD_W-1:0]         row_unit,
  output logic [BLOCK_W-1:0]        cycle_size,
  output logic [POS_W-1:0]          member_position,
  output logic [WORD_W-1:0]         member_device,
  output logic                      last_member,
  output logic                      last_result
);

  localparam int unsigned IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEVICES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DEVICES);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_DEVICES + 1);
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned DIVC_W = $clog2(DIV_STEPS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ERR     = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_CONCAT  = 4'd3;
  localparam logic [3:0] S_MIN     = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_STEP    = 4'd6;
  localparam logic [3:0] S_NEXT    = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;
  localparam logic [3:0] S_COMPACT = 4'd9;

  logic [WORD_W-1:0] id_mem   [MAX_DEVICES];
  logic [WORD_W-1:0] size_mem [MAX_DEVICES];
  logic [WORD_W-1:0] id_rd;
  logic [WORD_W-1:0] size_rd;

  logic              id_we;
  logic              size_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] id_wdata;
  logic [WORD_W-1:0] size_wdata;
  logic              rd_en;

  logic [3:0]         state;
  logic               phase;
  logic [UNIT_W-1:0]  unit;
  logic [CNT_W-1:0]   disk_count;
  logic               size_error_seen;
  logic [POS_W-1:0]   first_bad_slot;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   live;
  logic [CNT_W-1:0]   keep;
  status_t            err_status;
  logic [BLOCK_W-1:0] first;
  logic [BLOCK_W-1:0] next;
  logic [WORD_W-1:0]  offset;
  logic [WORD_W-1:0]  smallest;
  logic [WORD_W-1:0]  largest;
  logic [WORD_W-1:0]  dvd;
  logic [WORD_W-1:0]  rmd;
  logic [DIVC_W-1:0]  div_cnt;
  logic [WORD_W-1:0]  step;
  logic               final_row;

  logic               accept;
  logic               out_free;
  logic               is_last_idx;
  logic [CNT_W-1:0]   count_next;
  logic               load_bad;
  logic               seen_next;
  logic [POS_W-1:0]   bad_next;
  logic               chk_bad;
  logic               chk_seen;
  logic [POS_W-1:0]   chk_slot;
  logic [WORD_W-1:0]  rmd_shift;
  logic [WORD_W-1:0]  rmd_next;
  logic [WORD_W-1:0]  rem;
  logic               rem_keep;
  logic [BLOCK_W-1:0] len_ext;

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state != S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign is_last_idx = (CNT_W'(idx) + CNT_W'(1)) == live;

  always_comb begin
    count_next = disk_count;
    seen_next  = size_error_seen;
    bad_next   = first_bad_slot;
    load_bad   = too_small(device_size, unit);
    if (disk_count < CNT_MAX) begin
      count_next = disk_count + CNT_W'(1);
      if (load_bad && !size_error_seen) begin
        seen_next = 1'b1;
        bad_next  = POS_W'(disk_count);
      end
    end else begin
      count_next = CNT_OVER;
    end
  end

  always_comb begin
    chk_bad  = too_small(size_rd, unit) && (!size_error_seen || POS_W'(idx) < first_bad_slot);
    chk_seen = size_error_seen || chk_bad;
    chk_slot = chk_bad ? POS_W'(idx) : first_bad_slot;
  end

  always_comb begin
    rmd_shift = {rmd[WORD_W-2:0], dvd[WORD_W-1]};
    rmd_next  = (rmd_shift >= {1'b0, unit}) ? rmd_shift - {1'b0, unit} : rmd_shift;
    rem       = size_rd - step;
    rem_keep  = rem >= {1'b0, unit};
    len_ext   = BLOCK_W'(size_rd);
  end

  always_comb begin
    id_we      = 1'b0;
    size_we    = 1'b0;
    wr_addr    = idx;
    id_wdata   = device_id;
    size_wdata = device_size;
    rd_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && disk_count < CNT_MAX) begin
          id_we   = 1'b1;
          size_we = 1'b1;
          wr_addr = disk_count[IDX_W-1:0];
        end
      end
      S_CHECK: begin
        rd_en = !phase;
        if (phase) begin
          size_we    = 1'b1;
          size_wdata = size_rd - HEADER_SECTORS;
        end
      end
      S_COMPACT: begin
        rd_en = !phase;
        if (phase && rem_keep) begin
          id_we      = 1'b1;
          size_we    = 1'b1;
          wr_addr    = keep[IDX_W-1:0];
          id_wdata   = id_rd;
          size_wdata = rem;
        end
      end
      S_CONCAT, S_MIN, S_EMIT: rd_en = !phase;
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[wr_addr] <= id_wdata;
    end
    if (size_we) begin
      size_mem[wr_addr] <= size_wdata;
    end
    if (rd_en) begin
      id_rd   <= id_mem[idx];
      size_rd <= size_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit <= DEFAULT_UNIT;
    end else if (cfg_we) begin
      unit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= 1'b0;
      disk_count      <= '0;
      size_error_seen <= 1'b0;
      first_bad_slot  <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            disk_count      <= count_next;
            size_error_seen <= seen_next;
            first_bad_slot  <= bad_next;
            if (last_device) begin
              idx   <= '0;
              phase <= 1'b0;
              live  <= count_next;
              if (count_next < CNT_W'(2)) begin
                err_status <= ST_TOO_FEW;
                state      <= S_ERR;
              end else if (count_next > CNT_MAX) begin
                err_status <= ST_TOO_MANY;
                state      <= S_ERR;
              end else begin
                state <= S_CHECK;
              end
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            status          <= err_status;
            first_block     <= '0;
            last_block      <= '0;
            start_offset    <= '0;
            row_width       <= '0;
            row_unit        <= '0;
            cycle_size      <= '0;
            member_position <= (err_status == ST_TOO_SMALL) ? first_bad_slot : '0;
            member_device   <= '0;
            last_member     <= 1'b1;
            last_result     <= 1'b1;
            disk_count      <= '0;
            size_error_seen <= 1'b0;
            first_bad_slot  <= '0;
            state           <= S_IDLE;
          end
        end
        S_CHECK: begin
          phase <= !phase;
          if (phase) begin
            size_error_seen <= chk_seen;
            first_bad_slot  <= chk_slot;
            idx             <= idx + IDX_W'(1);
            if (is_last_idx) begin
              idx      <= '0;
              first    <= '0;
              offset   <= HEADER_SECTORS;
              smallest <= '1;
              largest  <= '0;
              if (chk_seen) begin
                err_status <= ST_TOO_SMALL;
                state      <= S_ERR;
              end else if (unit == '0) begin
                state <= S_CONCAT;
              end else begin
                state <= S_MIN;
              end
            end
          end
        end
        S_CONCAT: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (out_free) begin
            phase           <= 1'b0;
            out_valid       <= 1'b1;
            status          <= ST_ROW;
            first_block     <= first;
            last_block      <= first + len_ext - BLOCK_W'(1);
            start_offset    <= HEADER_SECTORS;
            row_width       <= WIDTH_W'(1);
            row_unit        <= size_rd;
            cycle_size      <= len_ext;
            member_position <= '0;
            member_device   <= id_rd;
            last_member     <= 1'b1;
            last_result     <= is_last_idx;
            first           <= first + len_ext;
            idx             <= idx + IDX_W'(1);
            if (is_last_idx) begin
              disk_count      <= '0;
              size_error_seen <= 1'b0;
              first_bad_slot  <= '0;
              state           <= S_IDLE;
            end
          end
        end
        S_MIN: begin
          phase <= !phase;
          if (phase) begin
            if (size_rd < smallest) begin
              smallest <= size_rd;
            end
            if (size_rd > largest) begin
              largest <= size_rd;
            end
            idx <= idx + IDX_W'(1);
            if (is_last_idx) begin
              idx     <= '0;
              rmd     <= '0;
              div_cnt <= '0;
              dvd     <= (size_rd < smallest) ? size_rd : smallest;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rmd     <= rmd_next;
          dvd     <= {dvd[WORD_W-2:0], 1'b0};
          div_cnt <= div_cnt + DIVC_W'(1);
          if (div_cnt == DIVC_W'(DIV_STEPS - 1)) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          step  <= smallest - rmd;
          state <= S_NEXT;
        end
        S_NEXT: begin
          next      <= first + BLOCK_W'(step) * BLOCK_W'(live);
          final_row <= (largest - step) < {1'b0, unit};
          phase     <= 1'b0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (out_free) begin
            phase           <= 1'b0;
            out_valid       <= 1'b1;
            status          <= ST_ROW;
            first_block     <= first;
            last_block      <= next - BLOCK_W'(1);
            start_offset    <= offset;
            row_width       <= WIDTH_W'(live);
            row_unit        <= {1'b0, unit};
            cycle_size      <= BLOCK_W'(unit) * BLOCK_W'(live);
            member_position <= POS_W'(idx);
            member_device   <= id_rd;
            last_member     <= is_last_idx;
            last_result     <= is_last_idx && final_row;
            idx             <= idx + IDX_W'(1);
            if (is_last_idx) begin
              idx <= '0;
              if (final_row) begin
                disk_count      <= '0;
                size_error_seen <= 1'b0;
                first_bad_slot  <= '0;
                state           <= S_IDLE;
              end else begin
                keep   <= '0;
                first  <= next;
                offset <= offset + step;
                state  <= S_COMPACT;
              end
            end
          end
        end
        S_COMPACT: begin
          phase <= !phase;
          if (phase) begin
            if (rem_keep) begin
              keep <= keep + CNT_W'(1);
            end
            idx <= idx + IDX_W'(1);
            if (is_last_idx) begin
              idx      <= '0;
              live     <= rem_keep ? keep + CNT_W'(1) : keep;
              smallest <= '1;
              largest  <= '0;
              state    <= S_MIN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    disk_count <= CNT_OVER)
    else $error("disk count above saturation");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIN || state == S_EMIT || state == S_COMPACT) |->
      (live != '0 && live <= CNT_MAX))
    else $error("row width out of range while planning");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_result && $past(!out_valid || !out_stall)) |-> state == S_IDLE)
    else $error("sequencer busy after final result");

  a_row_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ROW) |-> row_width != '0)
    else $error("row beat with zero width");
`endif

endmodule

`default_nettype wire

// ===== verif/stripe_layout_planner_top_tb.sv =====
// Self-checking testbench for the stripe layout planner: random sets against a layout predictor.
`timescale 1ns / 1ps
`default_nettype none

class plan_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [34:0] first_block;
    logic [34:0] last_block;
    logic [31:0] start_offset;
    logic [3:0]  row_width;
    logic [31:0] row_unit;
    logic [34:0] cycle_size;
    logic [2:0]  member_position;
    logic [31:0] member_device;
    logic        last_member;
    logic        last_result;
  } row_beat_t;

  row_beat_t pending_rows[$];
  int errors;
  logic [30:0] unit;
  logic [31:0] ids[8];
  logic [31:0] sizes[8];
  int count;
  bit size_bad;
  int bad_slot;

  function new();
    errors = 0;
    unit = slp_pkg::DEFAULT_UNIT;
    count = 0;
    size_bad = 0;
    bad_slot = 0;
  endfunction

  function bit undersized(logic [31:0] size, logic [30:0] u);
    if (u != 0) return {32'd0, size} < {33'd0, u} + 64'd32;
    return size <= 32;
  endfunction

  function void push_error(logic [1:0] st, int pos);
    row_beat_t r;
    r = '0;
    r.status = st;
    r.member_position = pos[2:0];
    r.last_member = 1;
    r.last_result = 1;
    pending_rows.push_back(r);
  endfunction

  function void note_disk(logic [31:0] id, logic [31:0] size, logic last);
    row_beat_t r;
    longint unsigned first, offset, stepv, next, len, smallest, cyc;
    int live, j, n;
    logic [31:0] rem;
    if (count < 8) begin
      ids[count] = id;
      sizes[count] = size;
      if (undersized(size, unit) && !size_bad) begin
        size_bad = 1;
        bad_slot = count;
      end
      count++;
    end else begin
      count = 9;
    end
    if (!last) return;
    if (count < 2) begin
      push_error(slp_pkg::ST_TOO_FEW, 0);
    end else if (count > 8) begin
      push_error(slp_pkg::ST_TOO_MANY, 0);
    end else begin
      for (int i = 0; i < count; i++)
        if (undersized(sizes[i], unit) && (!size_bad || i < bad_slot)) begin
          size_bad = 1;
          bad_slot = i;
        end
      if (size_bad) begin
        push_error(slp_pkg::ST_TOO_SMALL, bad_slot);
      end else if (unit == 0) begin
        first = 0;
        for (int i = 0; i < count; i++) begin
          len = sizes[i] - 32;
          next = first + len - 1;
          r = '0;
          r.first_block = first[34:0];
          r.last_block = next[34:0];
          r.start_offset = 32'd32;
          r.row_width = 4'd1;
          r.row_unit = len[31:0];
          r.cycle_size = len[34:0];
          r.member_device = ids[i];
          r.last_member = 1;
          r.last_result = (i == count - 1);
          pending_rows.push_back(r);
          first += len;
        end
      end else begin
        first = 0;
        offset = 32;
        live = count;
        n = 0;
        for (int i = 0; i < live; i++) sizes[i] -= 32;
        while (live > 0 && n + live <= 64) begin
          smallest = 64'hFFFF_FFFF;
          for (int i = 0; i < live; i++)
            if (sizes[i] < smallest) smallest = sizes[i];
          stepv = (smallest / unit) * unit;
          next = first + stepv * live;
          cyc = longint'(unit) * live;
          for (int i = 0; i < live; i++) begin
            r = '0;
            r.first_block = first[34:0];
            r.last_block = 35'(next - 1);
            r.start_offset = offset[31:0];
            r.row_width = 4'(live);
            r.row_unit = {1'b0, unit};
            r.cycle_size = cyc[34:0];
            r.member_position = 3'(i);
            r.member_device = ids[i];
            r.last_member = (i == live - 1);
            pending_rows.push_back(r);
            n++;
          end
          first = next;
          offset += stepv;
          j = 0;
          for (int i = 0; i < live; i++) begin
            rem = sizes[i] - stepv[31:0];
            if (rem >= {1'b0, unit}) begin
              sizes[j] = rem;
              ids[j] = ids[i];
              j++;
            end
          end
          if (j == live) break;
          live = j;
        end
        if (n > 0) pending_rows[pending_rows.size() - 1].last_result = 1;
      end
    end
    count = 0;
    size_bad = 0;
    bad_slot = 0;
  endfunction

  function void check_row(row_beat_t got);
    row_beat_t want;
    if (pending_rows.size() == 0) begin
      $display("%0t: unexpected beat %h", $time, got);
      errors++;
      return;
    end
    want = pending_rows.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch expected %h actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module stripe_layout_planner_top_tb;
  import slp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [UNIT_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] device_id = '0;
  logic [31:0] device_size = '0;
  logic last_device = 0;
  logic out_valid;
  logic out_stall = 0;
  status_t status;
  logic [34:0] first_block, last_block, cycle_size;
  logic [31:0] start_offset, row_unit, member_device;
  logic [3:0] row_width;
  logic [2:0] member_position;
  logic last_member, last_result;

  plan_scoreboard plans = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_on = 0;
  event hold_go;

  always #6 clk = ~clk;

  stripe_layout_planner_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .device_id(device_id),
    .device_size(device_size), .last_device(last_device),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .first_block(first_block), .last_block(last_block),
    .start_offset(start_offset), .row_width(row_width), .row_unit(row_unit),
    .cycle_size(cycle_size), .member_position(member_position),
    .member_device(member_device), .last_member(last_member),
    .last_result(last_result)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      plans.check_row({status, first_block, last_block, start_offset, row_width,
                       row_unit, cycle_size, member_position, member_device,
                       last_member, last_result});
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  always begin
    @(hold_go);
    hold_on <= 1;
    repeat (400) @(posedge clk);
    hold_on <= 0;
  end

  task automatic send_disk(input logic [31:0] id, input logic [31:0] size,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    device_id <= id;
    device_size <= size;
    last_device <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    plans.note_disk(id, size, last);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (plans.pending_rows.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic set_unit(input logic [30:0] u);
    drain();
    cfg_we <= 1;
    cfg_data <= u;
    @(posedge clk);
    cfg_we <= 0;
    plans.unit = u;
  endtask

  function automatic logic [31:0] pick_size(logic [30:0] u);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(40);
      2: return {1'b0, u} + 32 - $urandom_range(1);
      default: return {1'b0, u} * $urandom_range(1, 12) + 32 + $urandom_range(3000);
    endcase
  endfunction

  task automatic random_set(input logic [30:0] u);
    int n;
    case ($urandom_range(19))
      0: n = 1;
      1: n = $urandom_range(9, 11);
      default: n = $urandom_range(2, 8);
    endcase
    for (int i = 0; i < n; i++)
      send_disk($urandom, pick_size(u), i == n - 1);
  endtask

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [30:0] units[5];
    units = '{31'd0, 31'd1, 31'd7, 31'd2048, 31'h7FFF_FFFF};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed sets at reset unit
    send_disk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_disk(32'h0, 32'd5000, 0);
    send_disk(32'h1, 32'd9000, 0);
    send_disk(32'h2, 32'hFFFF_FFFF, 1);
    send_disk(32'h3, 32'd2079, 0);
    send_disk(32'h4, 32'd2080, 1);
    for (int i = 0; i < 9; i++) send_disk(i, 32'd4000, i == 8);
    drain();
    set_unit(31'd0);
    send_disk(32'hA, 32'd33, 0);
    send_disk(32'hB, 32'hFFFF_FFFF, 1);
    send_disk(32'hC, 32'd32, 0);
    send_disk(32'hD, 32'd100, 1);
    set_unit(31'h7FFF_FFFF);
    send_disk(32'hE, 32'hFFFF_FFFF, 0);
    send_disk(32'hF, 32'h8000_001F, 1);
    set_unit(31'd1);
    send_disk(32'h10, 32'd40, 0);
    set_unit(31'd100);
    send_disk(32'h11, 32'd50, 1);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 35 : 0;
      for (int k = 0; k < 5; k++) begin
        set_unit(k == 4 ? 31'($urandom_range(1, 5000)) : units[(k + phase) % 5]);
        if (k == 2) -> hold_go;
        repeat (4) random_set(plans.unit);
        drain();
        repeat (2) random_set(plans.unit);
      end
    end
    drain();
    if (plans.errors == 0 && plans.pending_rows.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/slp_pkg.sv
rtl/core/stripe_layout_planner_top.sv
verif/stripe_layout_planner_top_tb.sv
